// ===== rtl/core/pva_pkg.sv =====
// ----------------------------------------------------------------------------
// pva_pkg: shared definitions for the polyphonic voice allocator
// Holds field widths, event and action codes, the voice table entry and
// the detune generator constants.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int NumVoicesDef = 12;
    localparam int NumNotes     = 128;

    localparam int OpW   = 3;
    localparam int NoteW = 7;
    localparam int VelW  = 7;
    localparam int FinW  = 4;
    localparam int ActW  = 2;
    localparam int SlotW = 4;
    localparam int DetW  = 4;
    localparam int AgeW  = 32;
    localparam int SeedW = 32;

    localparam logic [VelW-1:0]  PedalDownMin = 7'd64;
    localparam logic [SeedW-1:0] LcgMul       = 32'd1664525;
    localparam logic [SeedW-1:0] LcgInc       = 32'd1013904223;
    // floor(x / 9) == (x * Mod9Mul) >> Mod9Shift for every 16-bit x.
    localparam logic [15:0]      Mod9Mul      = 16'd58255;
    localparam int               Mod9Shift    = 19;

    typedef enum logic [OpW-1:0] {
        OP_NOTE_ON       = 3'd0,
        OP_NOTE_OFF      = 3'd1,
        OP_SUSTAIN       = 3'd2,
        OP_ALL_NOTES_OFF = 3'd3,
        OP_ALL_SOUND_OFF = 3'd4,
        OP_VOICE_DONE    = 3'd5
    } t_opcode;

    typedef enum logic [ActW-1:0] {
        ACT_TRIGGER      = 2'd0,
        ACT_RELEASE      = 2'd1,
        ACT_RELEASE_FAST = 2'd2,
        ACT_KILL_ALL     = 2'd3
    } t_action;

    typedef struct packed {
        logic [NoteW-1:0] note;
        logic [AgeW-1:0]  age;
    } t_voice_entry;

endpackage

// ===== rtl/core/pva_ram.sv =====
// ----------------------------------------------------------------------------
// pva_ram: generic single-write, single-read synchronous RAM
// Read data is registered; a read of the entry written in the same cycle
// returns the new data.
// ----------------------------------------------------------------------------
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pva_lcg.sv =====
// ----------------------------------------------------------------------------
// pva_lcg: micro-detune generator
// A 32-bit linear congruential generator stepped once per trigger. The
// detune is ((seed >> 16) mod 9) - 4, registered from the stepped seed.
// ----------------------------------------------------------------------------
module pva_lcg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    output logic signed [pva_pkg::DetW-1:0]  o_detune
);

    logic [pva_pkg::SeedW-1:0] r_seed;
    logic [pva_pkg::SeedW-1:0] n_seed;
    logic [pva_pkg::DetW-1:0]  r_detune;
    logic [pva_pkg::DetW-1:0]  n_detune;

    logic [15:0] w_hi;
    logic [31:0] w_prod;
    logic [12:0] w_quot;
    logic [15:0] w_rem;

    always_comb begin
        n_seed = i_step ? (r_seed * pva_pkg::LcgMul + pva_pkg::LcgInc) : r_seed;
    end

    // Remainder by nine through a reciprocal multiply; the remainder is 0..8.
    always_comb begin
        w_hi     = r_seed[31:16];
        w_prod   = 32'(w_hi) * 32'(pva_pkg::Mod9Mul);
        w_quot   = w_prod[31:pva_pkg::Mod9Shift];
        w_rem    = w_hi - (16'({w_quot, 3'b000}) + 16'(w_quot));
        n_detune = w_rem[pva_pkg::DetW-1:0] - 4'd4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else begin
            r_seed <= n_seed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_detune <= n_detune;
    end

    assign o_detune = signed'(r_detune);

endmodule

// ===== rtl/core/poly_voice_allocator_sustain.sv =====
// ----------------------------------------------------------------------------
// poly_voice_allocator_sustain: polyphonic voice allocator with sustain pedal
// Maps note events onto a pool of voices with oldest-voice stealing and
// emits trigger, release and kill beats.
// ----------------------------------------------------------------------------
// One event is taken at a time; the voice table (note and age per voice)
// sits in a RAM with one read per cycle, so every event that looks at the
// voices walks it at most once. A note-on, a note-off with the pedal up and
// all-notes-off each walk the voices; pedal-up makes one voice pass to mark
// held notes, then one pass over the 128 notes through a note-to-voice RAM,
// which keeps the releases in note order. An event waits while its output
// beat is not taken.
// ----------------------------------------------------------------------------
module poly_voice_allocator_sustain #(
    parameter int NUM_VOICES = pva_pkg::NumVoicesDef
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pva_pkg::OpW-1:0]         i_opcode,
    input  logic [pva_pkg::NoteW-1:0]       i_note_number,
    input  logic [pva_pkg::VelW-1:0]        i_velocity,
    input  logic [pva_pkg::VelW-1:0]        i_pedal_value,
    input  logic [pva_pkg::FinW-1:0]        i_finished_voice,

    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pva_pkg::ActW-1:0]        o_action,
    output logic [pva_pkg::SlotW-1:0]       o_voice_slot,
    output logic [pva_pkg::NoteW-1:0]       o_out_note,
    output logic [pva_pkg::VelW-1:0]        o_out_velocity,
    output logic signed [pva_pkg::DetW-1:0] o_detune_half_cents,
    output logic                            o_last
);

    localparam int VW = $clog2(NUM_VOICES);
    localparam int CW = $clog2(pva_pkg::NumNotes);
    localparam logic [VW-1:0] LastVoice = VW'(NUM_VOICES - 1);
    localparam logic [CW-1:0] LastNote  = CW'(pva_pkg::NumNotes - 1);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_ON_SCAN  = 8'b0000_0010,
        S_ON_WRITE = 8'b0000_0100,
        S_OFF_SCAN = 8'b0000_1000,
        S_PB_BUILD = 8'b0001_0000,
        S_PB_WALK  = 8'b0010_0000,
        S_ANO_SCAN = 8'b0100_0000,
        S_KILL     = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [NUM_VOICES-1:0]        r_active, n_active;
    logic [pva_pkg::NumNotes-1:0] r_held, n_held;
    logic [pva_pkg::NumNotes-1:0] r_pend, n_pend;
    logic                         r_pedal, n_pedal;
    logic [VW-1:0]                r_idx, n_idx;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic [pva_pkg::NoteW-1:0]    r_note, n_note;
    logic [pva_pkg::VelW-1:0]     r_vel, n_vel;
    logic [pva_pkg::AgeW-1:0]     r_age, n_age;
    logic                         r_has_match, n_has_match;
    logic [VW-1:0]                r_match_idx, n_match_idx;
    logic                         r_has_free, n_has_free;
    logic [VW-1:0]                r_free_idx, n_free_idx;
    logic [VW-1:0]                r_min_idx, n_min_idx;
    logic [pva_pkg::AgeW-1:0]     r_min_age, n_min_age;
    logic [VW-1:0]                r_sel, n_sel;

    // Output register.
    logic                            r_ovalid;
    logic [pva_pkg::ActW-1:0]        r_oact;
    logic [pva_pkg::SlotW-1:0]       r_oslot;
    logic [pva_pkg::NoteW-1:0]       r_onote;
    logic [pva_pkg::VelW-1:0]        r_ovel;
    logic [pva_pkg::DetW-1:0]        r_odet;
    logic                            r_olast;

    logic                            w_emit_req;
    logic                            w_out_free;
    logic [pva_pkg::ActW-1:0]        w_emit_act;
    logic [pva_pkg::SlotW-1:0]       w_emit_slot;
    logic [pva_pkg::NoteW-1:0]       w_emit_note;
    logic [pva_pkg::VelW-1:0]        w_emit_vel;
    logic [pva_pkg::DetW-1:0]        w_emit_det;
    logic                            w_emit_last;

    logic                            w_lcg_step;
    logic signed [pva_pkg::DetW-1:0] w_detune;

    logic                            w_vram_we;
    pva_pkg::t_voice_entry           w_vram_wdata;
    pva_pkg::t_voice_entry           w_vram_rdata;
    logic                            w_map_we;
    logic [VW-1:0]                   w_map_rdata;

    logic                            w_cur_act;
    logic                            w_idx_last;
    logic                            w_more_voice;
    logic                            w_more_note;
    logic                            w_off_req;

    pva_lcg u_lcg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_lcg_step),
        .o_detune (w_detune)
    );

    pva_ram #(
        .WIDTH ($bits(pva_pkg::t_voice_entry)),
        .DEPTH (NUM_VOICES)
    ) u_voice_ram (
        .i_clk   (i_clk),
        .i_we    (w_vram_we),
        .i_waddr (r_sel),
        .i_wdata (w_vram_wdata),
        .i_raddr (n_idx),
        .o_rdata (w_vram_rdata)
    );

    // Note-to-voice map, written for held notes during the pedal-up pass.
    pva_ram #(
        .WIDTH (VW),
        .DEPTH (pva_pkg::NumNotes)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (w_vram_rdata.note),
        .i_wdata (r_idx),
        .i_raddr (n_cnt),
        .o_rdata (w_map_rdata)
    );

    assign o_ready      = (r_state == S_IDLE);
    assign w_out_free   = !r_ovalid || i_ready;
    assign w_cur_act    = r_active[r_idx];
    assign w_idx_last   = (r_idx == LastVoice);
    assign w_vram_wdata = '{note: r_note, age: r_age};
    assign w_off_req    = ((i_opcode == pva_pkg::OP_NOTE_ON) && (i_velocity == '0))
                          || (i_opcode == pva_pkg::OP_NOTE_OFF);

    // Lookahead for the last flag of multi-beat events.
    always_comb begin
        w_more_voice = 1'b0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            if ((v > int'(r_idx)) && r_active[v]) begin
                w_more_voice = 1'b1;
            end
        end
    end

    always_comb begin
        w_more_note = 1'b0;
        for (int k = 0; k < pva_pkg::NumNotes; k++) begin
            if ((k > int'(r_cnt)) && r_pend[k]) begin
                w_more_note = 1'b1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_held      = r_held;
        n_pend      = r_pend;
        n_pedal     = r_pedal;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_note      = r_note;
        n_vel       = r_vel;
        n_age       = r_age;
        n_has_match = r_has_match;
        n_match_idx = r_match_idx;
        n_has_free  = r_has_free;
        n_free_idx  = r_free_idx;
        n_min_idx   = r_min_idx;
        n_min_age   = r_min_age;
        n_sel       = r_sel;
        w_emit_req  = 1'b0;
        w_emit_act  = pva_pkg::ACT_TRIGGER;
        w_emit_slot = '0;
        w_emit_note = '0;
        w_emit_vel  = '0;
        w_emit_det  = '0;
        w_emit_last = 1'b1;
        w_lcg_step  = 1'b0;
        w_vram_we   = 1'b0;
        w_map_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_cnt = '0;
                if (i_valid) begin
                    n_note = i_note_number;
                    n_vel  = i_velocity;
                    if (w_off_req) begin
                        if (r_pedal) begin
                            n_held[i_note_number] = 1'b1;
                        end else begin
                            n_state = S_OFF_SCAN;
                        end
                    end else begin
                        case (i_opcode)
                            pva_pkg::OP_NOTE_ON: begin
                                n_held[i_note_number] = 1'b0;
                                w_lcg_step  = 1'b1;
                                n_age       = r_age + 1'b1;
                                n_has_match = 1'b0;
                                n_has_free  = 1'b0;
                                n_state     = S_ON_SCAN;
                            end
                            pva_pkg::OP_SUSTAIN: begin
                                n_pedal = (i_pedal_value >= pva_pkg::PedalDownMin);
                                if (i_pedal_value < pva_pkg::PedalDownMin) begin
                                    n_pend  = '0;
                                    n_state = S_PB_BUILD;
                                end
                            end
                            pva_pkg::OP_ALL_NOTES_OFF: begin
                                n_state = S_ANO_SCAN;
                            end
                            pva_pkg::OP_ALL_SOUND_OFF: begin
                                n_active = '0;
                                n_held   = '0;
                                n_pedal  = 1'b0;
                                n_state  = S_KILL;
                            end
                            pva_pkg::OP_VOICE_DONE: begin
                                for (int v = 0; v < NUM_VOICES; v++) begin
                                    if (int'(i_finished_voice) == v) begin
                                        n_active[v] = 1'b0;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end

            // One voice per cycle: reuse match, first free voice, oldest voice.
            S_ON_SCAN: begin
                if (w_cur_act && (w_vram_rdata.note == r_note) && !r_has_match) begin
                    n_has_match = 1'b1;
                    n_match_idx = r_idx;
                end
                if (!w_cur_act && !r_has_free) begin
                    n_has_free = 1'b1;
                    n_free_idx = r_idx;
                end
                if ((r_idx == '0) || (w_vram_rdata.age < r_min_age)) begin
                    n_min_age = w_vram_rdata.age;
                    n_min_idx = r_idx;
                end
                if (w_idx_last) begin
                    n_sel   = n_has_match ? n_match_idx :
                              (n_has_free ? n_free_idx : n_min_idx);
                    n_state = S_ON_WRITE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_ON_WRITE: begin
                w_vram_we   = 1'b1;
                w_emit_req  = 1'b1;
                w_emit_act  = pva_pkg::ACT_TRIGGER;
                w_emit_slot = pva_pkg::SlotW'(r_sel);
                w_emit_note = r_note;
                w_emit_vel  = r_vel;
                w_emit_det  = w_detune;
                if (w_out_free) begin
                    n_active[r_sel] = 1'b1;
                    n_state         = S_IDLE;
                end
            end

            S_OFF_SCAN: begin
                if (w_cur_act && (w_vram_rdata.note == r_note)) begin
                    w_emit_req  = 1'b1;
                    w_emit_act  = pva_pkg::ACT_RELEASE;
                    w_emit_slot = pva_pkg::SlotW'(r_idx);
                    w_emit_note = w_vram_rdata.note;
                    if (w_out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (w_idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_ANO_SCAN: begin
                if (w_cur_act) begin
                    w_emit_req  = 1'b1;
                    w_emit_act  = pva_pkg::ACT_RELEASE_FAST;
                    w_emit_slot = pva_pkg::SlotW'(r_idx);
                    w_emit_note = w_vram_rdata.note;
                    w_emit_last = !w_more_voice;
                end
                if (!w_cur_act || w_out_free) begin
                    if (w_idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            // Mark every held note that still has an active voice.
            S_PB_BUILD: begin
                if (w_cur_act && r_held[w_vram_rdata.note]) begin
                    n_pend[w_vram_rdata.note] = 1'b1;
                    w_map_we = 1'b1;
                end
                if (w_idx_last) begin
                    n_state = S_PB_WALK;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            S_PB_WALK: begin
                if (r_pend[r_cnt]) begin
                    w_emit_req  = 1'b1;
                    w_emit_act  = pva_pkg::ACT_RELEASE;
                    w_emit_slot = pva_pkg::SlotW'(w_map_rdata);
                    w_emit_note = r_cnt;
                    w_emit_last = !w_more_note;
                end
                if (!r_pend[r_cnt] || w_out_free) begin
                    if (r_cnt == LastNote) begin
                        n_held  = '0;
                        n_pend  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end

            S_KILL: begin
                w_emit_req = 1'b1;
                w_emit_act = pva_pkg::ACT_KILL_ALL;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_held      <= '0;
            r_pend      <= '0;
            r_pedal     <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_age       <= '0;
            r_has_match <= 1'b0;
            r_has_free  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_held      <= n_held;
            r_pend      <= n_pend;
            r_pedal     <= n_pedal;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_age       <= n_age;
            r_has_match <= n_has_match;
            r_has_free  <= n_has_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_note      <= n_note;
        r_vel       <= n_vel;
        r_match_idx <= n_match_idx;
        r_free_idx  <= n_free_idx;
        r_min_idx   <= n_min_idx;
        r_min_age   <= n_min_age;
        r_sel       <= n_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit_req && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_req && w_out_free) begin
            r_oact  <= w_emit_act;
            r_oslot <= w_emit_slot;
            r_onote <= w_emit_note;
            r_ovel  <= w_emit_vel;
            r_odet  <= w_emit_det;
            r_olast <= w_emit_last;
        end
    end

    assign o_valid             = r_ovalid;
    assign o_action            = r_oact;
    assign o_voice_slot        = r_oslot;
    assign o_out_note          = r_onote;
    assign o_out_velocity      = r_ovel;
    assign o_detune_half_cents = signed'(r_odet);
    assign o_last              = r_olast;

endmodule
